// ===== sv/mstt_pkg.sv =====
package mstt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_W         = 32;
    localparam int COUNT_W        = 16;

    // Command modes.
    localparam logic [2:0] MODE_CREATE    = 3'd0;
    localparam logic [2:0] MODE_DESTROY   = 3'd1;
    localparam logic [2:0] MODE_TICK      = 3'd2;
    localparam logic [2:0] MODE_ROUND_END = 3'd3;
    localparam logic [2:0] MODE_MAP_END   = 3'd4;

    // Result codes.
    localparam logic [2:0] EV_CREATED = 3'd0;
    localparam logic [2:0] EV_FULL    = 3'd1;
    localparam logic [2:0] EV_FIRED   = 3'd2;
    localparam logic [2:0] EV_ACK     = 3'd3;
    localparam logic [2:0] EV_DONE    = 3'd4;

    // Lifetime rules.
    localparam logic [1:0] LIFE_ONCE  = 2'd0;
    localparam logic [1:0] LIFE_ROUND = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CREATE,
        ST_TICK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [TIME_W-1:0]  period;
        logic [COUNT_W-1:0] limit;
        logic [COUNT_W-1:0] fired;
        logic [1:0]         life;
    } t_slot_rec;

endpackage

// ===== sv/mstt_if.sv =====
interface mstt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] now;
    logic [31:0] delay;
    logic [31:0] period;
    logic [15:0] run_limit;
    logic [1:0]  lifetime;
    logic [3:0]  target_slot;

    modport source (
        output valid, mode, now, delay, period, run_limit, lifetime, target_slot,
        input  ready
    );
    modport sink (
        input  valid, mode, now, delay, period, run_limit, lifetime, target_slot,
        output ready
    );
endinterface

interface mstt_evt_if;
    logic       valid;
    logic       ready;
    logic [3:0] slot;
    logic [2:0] event_res;
    logic       retired;
    logic       last;

    modport source (
        output valid, slot, event_res, retired, last,
        input  ready
    );
    modport sink (
        input  valid, slot, event_res, retired, last,
        output ready
    );
endinterface

// ===== sv/mstt_ram.sv =====
module mstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/multi_slot_timer_table.sv =====
// Channel   Dir  Modport  Carries
// i_cmd     in   sink     mode, now, delay, period, run_limit, lifetime, target_slot
// o_evt     out  source   slot, event_res, retired, last
//
// Create walks the slots one per cycle to the lowest free one.
// Tick walks every slot one per cycle through the record RAM and the shared saturating
// adder, then sends the closing item. Other commands go straight to the closing item.
// A stalled result output holds the walk at the current slot until the item is taken.
// Reset (synchronous, active low) frees every slot; slot records need no clearing.
module multi_slot_timer_table
    import mstt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mstt_cmd_if.sink   i_cmd,
    mstt_evt_if.source o_evt
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [NUM_TIMERS-1:0] r_live;
    logic [NUM_TIMERS-1:0] r_round;

    logic [TIME_W-1:0]  r_now, r_delay, r_period;
    logic [COUNT_W-1:0] r_limit;
    logic [1:0]         r_life;
    logic [3:0]         r_fin_slot;
    logic [2:0]         r_fin_ev;

    logic       r_out_valid;
    logic [3:0] r_out_slot;
    logic [2:0] r_out_ev;
    logic       r_out_ret;
    logic       r_out_last;

    logic        cmd_acc;
    logic        out_free;
    logic        idx_last;
    logic        due;
    logic        fire_ret;
    logic [IW+3:0] idx_ext;
    logic [IW+3:0] tgt_ext;
    logic          tgt_in;
    logic [IW-1:0] tgt_idx;

    t_slot_rec          rec;
    t_slot_rec          wrec;
    logic [TIME_W-1:0]  add_b;
    logic [TIME_W:0]    add_sum;
    logic [TIME_W-1:0]  add_sat;
    logic [COUNT_W-1:0] fired_inc;

    logic       ram_we;
    logic [$bits(t_slot_rec)-1:0] ram_rdata;
    logic       live_set;
    logic       live_clr;
    logic       out_load;
    logic [3:0] out_slot;
    logic [2:0] out_ev;
    logic       out_ret;
    logic       out_last;

    mstt_ram #(
        .WIDTH ($bits(t_slot_rec)),
        .DEPTH (NUM_TIMERS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (wrec),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_evt.ready;
    assign idx_last    = (r_idx == LAST_IDX);
    assign idx_ext     = (IW + 4)'(r_idx);
    assign tgt_ext     = (IW + 4)'(i_cmd.target_slot);
    assign tgt_in      = tgt_ext < (IW + 4)'(NUM_TIMERS);
    assign tgt_idx     = tgt_ext[IW-1:0];

    // The RAM is read at the next index, so its output always holds the record of r_idx.
    assign rec = t_slot_rec'(ram_rdata);

    // Shared saturating adder: first deadline on create, rearm deadline on tick.
    assign add_b   = (r_state == ST_CREATE) ? r_delay : rec.period;
    assign add_sum = (TIME_W + 1)'(r_now) + (TIME_W + 1)'(add_b);
    assign add_sat = add_sum[TIME_W] ? '1 : add_sum[TIME_W-1:0];

    assign due       = r_live[r_idx] && !(rec.deadline > r_now);
    assign fired_inc = (rec.fired == COUNT_MAX) ? rec.fired : rec.fired + 1'b1;
    assign fire_ret  = (rec.life == LIFE_ONCE) || (fired_inc == rec.limit);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cmd_acc) begin
                    case (i_cmd.mode)
                        MODE_CREATE: n_state = ST_CREATE;
                        MODE_TICK:   n_state = ST_TICK;
                        default:     n_state = ST_FINISH;
                    endcase
                end
            end
            ST_CREATE: begin
                if (out_free && (!r_live[r_idx] || idx_last)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TICK: begin
                if ((!due || out_free) && idx_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_idx    = r_idx;
        ram_we   = 1'b0;
        wrec     = rec;
        live_set = 1'b0;
        live_clr = 1'b0;
        out_load = 1'b0;
        out_slot = '0;
        out_ev   = EV_ACK;
        out_ret  = 1'b0;
        out_last = 1'b1;
        case (r_state)
            ST_CREATE: begin
                wrec.deadline = add_sat;
                wrec.period   = r_period;
                wrec.limit    = r_limit;
                wrec.fired    = '0;
                wrec.life     = r_life;
                if (!r_live[r_idx]) begin
                    if (out_free) begin
                        ram_we   = 1'b1;
                        live_set = 1'b1;
                        out_load = 1'b1;
                        out_slot = idx_ext[3:0];
                        out_ev   = EV_CREATED;
                        n_idx    = '0;
                    end
                end else if (idx_last) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        out_ev   = EV_FULL;
                        n_idx    = '0;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TICK: begin
                wrec.deadline = add_sat;
                wrec.fired    = fired_inc;
                if (!due || out_free) begin
                    n_idx = idx_last ? '0 : r_idx + 1'b1;
                end
                if (due && out_free) begin
                    out_load = 1'b1;
                    out_slot = idx_ext[3:0];
                    out_ev   = EV_FIRED;
                    out_ret  = fire_ret;
                    out_last = 1'b0;
                    live_clr = fire_ret;
                    ram_we   = !fire_ret;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_slot = r_fin_slot;
                    out_ev   = r_fin_ev;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
            if (live_set) begin
                r_live[r_idx] <= 1'b1;
            end
            if (live_clr) begin
                r_live[r_idx] <= 1'b0;
            end
            if (cmd_acc) begin
                case (i_cmd.mode)
                    MODE_DESTROY: begin
                        if (tgt_in) begin
                            r_live[tgt_idx] <= 1'b0;
                        end
                    end
                    MODE_ROUND_END: r_live <= r_live & ~r_round;
                    MODE_MAP_END:   r_live <= '0;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_now      <= i_cmd.now;
            r_delay    <= i_cmd.delay;
            r_period   <= i_cmd.period;
            r_limit    <= i_cmd.run_limit;
            r_life     <= i_cmd.lifetime;
            r_fin_slot <= (i_cmd.mode == MODE_DESTROY) ? i_cmd.target_slot : 4'd0;
            r_fin_ev   <= (i_cmd.mode == MODE_TICK) ? EV_DONE : EV_ACK;
        end
        if (live_set) begin
            r_round[r_idx] <= (r_life == LIFE_ROUND);
        end
        if (out_load) begin
            r_out_slot <= out_slot;
            r_out_ev   <= out_ev;
            r_out_ret  <= out_ret;
            r_out_last <= out_last;
        end
    end

    assign o_evt.valid     = r_out_valid;
    assign o_evt.slot      = r_out_slot;
    assign o_evt.event_res = r_out_ev;
    assign o_evt.retired   = r_out_ret;
    assign o_evt.last      = r_out_last;

`ifndef SYNTHESIS
    // The walk index must rest at zero between commands so the RAM output lines up.
    a_idle_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_idx == '0))
        else $error("slot index not at zero while idle");

    // At most one slot is taken per cycle.
    a_live_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_live) <= $countones($past(r_live)) + 1))
        else $error("more than one slot taken in a cycle");

    // Only the closing item of a command carries last.
    a_last_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.valid |-> (o_evt.last == (o_evt.event_res != EV_FIRED)))
        else $error("last flag does not match result code");

    // A retired firing must leave its slot free.
    a_retire_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && out_ret) |=> !r_live[$past(r_idx)])
        else $error("retired slot still live");
`endif

endmodule
